@@ rtl/sha256_byte_stream_hasher_defines.svh @@
// Assertion macros used by the top-level hasher module.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SHBH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error("assertion failed");

`define SHBH_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

`else

`define SHBH_ASSERT(lbl, clk, rstn, prop)

`define SHBH_ASSERT_MSG(lbl, clk, rstn, prop, msg)

`endif

`endif

@@ rtl/shbh_pkg.sv @@
`default_nettype none
package shbh_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam logic [5:0]  LenOffset  = 6'd56;
  localparam logic [7:0]  PadByte    = 8'h80;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_PADLEN = 2'd1;
  localparam logic [1:0] KIND_PAD    = 2'd2;
  localparam logic [1:0] KIND_LEN    = 2'd3;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       load;
    logic       round;
    logic [5:0] t;
    logic [1:0] kind;
    logic [5:0] fill;
  } msg_ctl_t;

  localparam word_t Iv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundKey [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

@@ rtl/shbh_if.sv @@
`default_nettype none
interface shbh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       finish;
  modport source (output valid, data_byte, finish, input ready);
  modport sink   (input valid, data_byte, finish, output ready);
endinterface

interface shbh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface
`default_nettype wire

@@ rtl/sha256_byte_stream_hasher.sv @@
// SHA-256 over a byte stream, one byte per data beat. The 64th byte of a block
// starts a compression that holds off input (one read of the block memory,
// 64 rounds of the single round unit, one chaining add).
// A finish beat runs one or two such compressions (two when 56 or more bytes of
// the last block are filled), then drives the eight digest words, word 0 first,
// one per accepted output beat, and the block is ready for the next message.
`default_nettype none
`include "sha256_byte_stream_hasher_defines.svh"
module sha256_byte_stream_hasher (
  input  wire logic clk,
  input  wire logic rst_n,
  shbh_in_if.sink   in_ch,
  shbh_out_if.source out_ch
);
  import shbh_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  t_r, t_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic [2:0]  idx_r, idx_nxt;
  word_t       h_r [8];
  word_t       v_r [8];
  word_t       w_t;
  word_t       t1, t2;
  msg_ctl_t    ctl;
  logic        in_acc, out_acc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.digest_word = h_r[idx_r];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last        = (idx_r == 3'd7);
  assign out_acc = out_ch.valid && out_ch.ready;

  assign ctl.load  = (state_r == S_LOAD);
  assign ctl.round = (state_r == S_ROUND);
  assign ctl.t     = t_r;
  assign ctl.kind  = kind_r;
  assign ctl.fill  = fill_r;

  shbh_msg u_msg (
    .clk     (clk),
    .wr_en   (in_acc && !in_ch.finish),
    .wr_addr (fill_r),
    .wr_byte (in_ch.data_byte),
    .ctl     (ctl),
    .bit_len (len_r),
    .w_t     (w_t)
  );

  assign t1 = v_r[7]
            + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + RoundKey[t_r] + w_t;
  assign t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    kind_nxt  = kind_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.finish) begin
            kind_nxt  = (fill_r < LenOffset) ? KIND_PADLEN : KIND_PAD;
            state_nxt = S_LOAD;
          end else begin
            len_nxt  = len_r + 64'd8;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              kind_nxt  = KIND_DATA;
              state_nxt = S_LOAD;
            end
          end
        end
      end
      S_LOAD: begin
        t_nxt     = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        t_nxt = t_r + 6'd1;
        if (t_r == 6'(Rounds - 1)) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        priority if (kind_r == KIND_DATA) begin
          state_nxt = S_IDLE;
        end else if (kind_r == KIND_PAD) begin
          kind_nxt  = KIND_LEN;
          state_nxt = S_LOAD;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            fill_nxt  = '0;
            len_nxt   = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      t_r     <= '0;
      kind_r  <= KIND_DATA;
      fill_r  <= '0;
      len_r   <= '0;
      idx_r   <= '0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= Iv[i];
      end
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
      kind_r  <= kind_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      if (state_r == S_FINAL) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end else if (out_acc && idx_r == 3'd7) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= Iv[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (state_r == S_ROUND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  `SHBH_ASSERT(a_ready_excl_out, clk, rst_n, in_ch.ready |-> !out_ch.valid)
  `SHBH_ASSERT_MSG(a_round_end, clk, rst_n, (state_r == S_ROUND && t_r == 6'd63) |=> (state_r == S_FINAL), "round count overran")
  `SHBH_ASSERT_MSG(a_last_frees, clk, rst_n, (out_acc && out_ch.last) |=> (in_ch.ready && fill_r == 6'd0 && len_r == 64'd0), "state not cleared after digest")
endmodule
`default_nettype wire

@@ rtl/shbh_msg.sv @@
`default_nettype none
module shbh_msg (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [5:0]       wr_addr,
  input  wire logic [7:0]       wr_byte,
  input  wire shbh_pkg::msg_ctl_t ctl,
  input  wire logic [63:0]      bit_len,
  output logic [31:0]           w_t
);
  import shbh_pkg::*;

  word_t mem [BlockWords];
  word_t rd_data_r;
  word_t win_r [16];
  logic [3:0] rd_addr;
  word_t load_w;
  word_t sched_w;
  logic [5:0] pos;
  logic [7:0] b;

  assign rd_addr = ctl.load ? 4'd0 : ctl.t[3:0] + 4'd1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][8 * (3 - wr_addr[1:0]) +: 8] <= wr_byte;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    load_w = '0;
    pos    = '0;
    b      = '0;
    for (int k = 0; k < 4; k++) begin
      pos = {ctl.t[3:0], 2'(k)};
      b   = rd_data_r[8 * (3 - k) +: 8];
      unique case (ctl.kind)
        KIND_DATA: load_w[8 * (3 - k) +: 8] = b;
        KIND_PADLEN, KIND_PAD: begin
          if (pos < ctl.fill) begin
            load_w[8 * (3 - k) +: 8] = b;
          end else if (pos == ctl.fill) begin
            load_w[8 * (3 - k) +: 8] = PadByte;
          end else begin
            load_w[8 * (3 - k) +: 8] = 8'h00;
          end
        end
        default: load_w[8 * (3 - k) +: 8] = 8'h00;
      endcase
    end
    if (ctl.kind == KIND_PADLEN || ctl.kind == KIND_LEN) begin
      if (ctl.t[3:0] == 4'd14) begin
        load_w = bit_len[63:32];
      end else if (ctl.t[3:0] == 4'd15) begin
        load_w = bit_len[31:0];
      end
    end
  end

  assign sched_w = (rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10))
                 + win_r[9]
                 + (rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3))
                 + win_r[0];

  assign w_t = (ctl.t < 6'd16) ? load_w : sched_w;

  always_ff @(posedge clk) begin
    if (ctl.round) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[15] <= w_t;
    end
  end
endmodule
`default_nettype wire
